// ===== hw/rtl/bsmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmpq_pkg
// Shared codes and types of the bounded stable min priority queue.
// ----------------------------------------------------------------------------
package bsmpq_pkg;

   // Fixed field widths
   localparam int OP_BITS     = 2;
   localparam int COUNT_BITS  = 5;
   localparam int STATUS_BITS = 2;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_ENQ = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DEQ = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLR = 2'd2;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // sorted insert of the new entry
      logic remove;   // shift everything toward the head
      logic flush;    // drop all entries
   } cell_cmd_type;

endpackage

// ===== hw/rtl/bsmpq_cell.sv =====
// ----------------------------------------------------------------------------
// bsmpq_cell
// One slot of the sorted chain: holds a valid bit, a value and a priority,
// and trades entries with its left and right neighbors.
// ----------------------------------------------------------------------------
module bsmpq_cell #(
   parameter int VALUE_BITS    = 32,
   parameter int PRIORITY_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bsmpq_pkg::cell_cmd_type   cmd,
   input  logic [VALUE_BITS-1:0]     new_value,
   input  logic [PRIORITY_BITS-1:0]  new_priority,
   // left neighbor (toward the head)
   input  logic                      prev_valid,
   input  logic                      prev_keep,
   input  logic [VALUE_BITS-1:0]     prev_value,
   input  logic [PRIORITY_BITS-1:0]  prev_priority,
   // right neighbor (toward the tail)
   input  logic                      next_valid,
   input  logic [VALUE_BITS-1:0]     next_value,
   input  logic [PRIORITY_BITS-1:0]  next_priority,
   // own state
   output logic                      valid,
   output logic                      keep,
   output logic [VALUE_BITS-1:0]     value,
   output logic [PRIORITY_BITS-1:0]  priority_out
);

   logic                     valid_ff, valid_in;
   logic [VALUE_BITS-1:0]    value_ff, value_in;
   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;

   // entry stays put on insert when it is not later than the new one
   assign keep = valid_ff && (priority_ff <= new_priority);

   // next state
   always_comb begin
      valid_in    = valid_ff;
      value_in    = value_ff;
      priority_in = priority_ff;
      if (cmd.flush) begin
         valid_in = 1'b0;
      end else if (cmd.insert) begin
         valid_in = prev_valid;
         if (!keep) begin
            if (prev_keep) begin
               value_in    = new_value;
               priority_in = new_priority;
            end else begin
               value_in    = prev_value;
               priority_in = prev_priority;
            end
         end
      end else if (cmd.remove) begin
         valid_in    = next_valid;
         value_in    = next_value;
         priority_in = next_priority;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   assign valid        = valid_ff;
   assign value        = value_ff;
   assign priority_out = priority_ff;

endmodule

// ===== hw/rtl/bounded_stable_min_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// bounded_stable_min_priority_queue_core
// Bounded min priority queue kept sorted in a chain of cells; equal
// priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | op, item_value, item_priority
//  rsp     | out       | rsp_valid / rsp_ready | head_value, head_priority,
//          |           |                       | entry_count, is_empty, status
//
//  All cells compare the new priority in parallel and shift by one place, so
//  one operation per cycle is sustained while responses are not stalled.
//  The response is valid the cycle after acceptance and reads cell 0.
//  Reset clears all valid bits and the count at once; no clearing pass.
//  A stalled response holds the request side; a request is taken in the same
//  cycle the pending response is taken.
// ----------------------------------------------------------------------------
module bounded_stable_min_priority_queue_core #(
   parameter int CAPACITY      = 16,
   parameter int VALUE_BITS    = 32,
   parameter int PRIORITY_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bsmpq_pkg::OP_BITS-1:0]         req_op,
   input  logic [VALUE_BITS-1:0]                 req_item_value,
   input  logic [PRIORITY_BITS-1:0]              req_item_priority,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [VALUE_BITS-1:0]                 rsp_head_value,
   output logic [PRIORITY_BITS-1:0]              rsp_head_priority,
   output logic [bsmpq_pkg::COUNT_BITS-1:0]      rsp_entry_count,
   output logic                                  rsp_is_empty,
   output logic [bsmpq_pkg::STATUS_BITS-1:0]     rsp_status
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic                               accept;
   logic                               full, empty;
   bsmpq_pkg::cell_cmd_type            cmd;
   logic [bsmpq_pkg::STATUS_BITS-1:0]  status_ff, status_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [CW+bsmpq_pkg::COUNT_BITS-1:0] count_ext;

   logic                     cell_valid [CAPACITY];
   logic                     cell_keep  [CAPACITY];
   logic [VALUE_BITS-1:0]    cell_value [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // sorted prefix: full when the tail cell holds an entry
   assign full  = cell_valid[CAPACITY-1];
   assign empty = !cell_valid[0];

   // decode operation
   always_comb begin
      cmd       = '0;
      status_in = status_ff;
      count_in  = count_ff;
      if (accept) begin
         status_in = bsmpq_pkg::ST_DONE;
         case (req_op)
            bsmpq_pkg::OP_ENQ: begin
               if (full) begin
                  status_in = bsmpq_pkg::ST_FULL;
               end else begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + CW'(1);
               end
            end
            bsmpq_pkg::OP_DEQ: begin
               if (empty) begin
                  status_in = bsmpq_pkg::ST_EMPTY;
               end else begin
                  cmd.remove = 1'b1;
                  count_in   = count_ff - CW'(1);
               end
            end
            bsmpq_pkg::OP_CLR: begin
               cmd.flush = 1'b1;
               count_in  = '0;
            end
            default: begin
               // unused code: queue unchanged
            end
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= bsmpq_pkg::ST_DONE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
      end
   end

   // chain of cells, head at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     prev_valid, prev_keep, next_valid;
      logic [VALUE_BITS-1:0]    prev_value, next_value;
      logic [PRIORITY_BITS-1:0] prev_prio, next_prio;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_keep  = 1'b1;
         assign prev_value = req_item_value;
         assign prev_prio  = req_item_priority;
      end else begin : g_body
         assign prev_valid = cell_valid[i-1];
         assign prev_keep  = cell_keep[i-1];
         assign prev_value = cell_value[i-1];
         assign prev_prio  = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_value = '0;
         assign next_prio  = '0;
      end else begin : g_inner
         assign next_valid = cell_valid[i+1];
         assign next_value = cell_value[i+1];
         assign next_prio  = cell_prio[i+1];
      end

      bsmpq_cell #(
         .VALUE_BITS    (VALUE_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .new_value     (req_item_value),
         .new_priority  (req_item_priority),
         .prev_valid    (prev_valid),
         .prev_keep     (prev_keep),
         .prev_value    (prev_value),
         .prev_priority (prev_prio),
         .next_valid    (next_valid),
         .next_value    (next_value),
         .next_priority (next_prio),
         .valid         (cell_valid[i]),
         .keep          (cell_keep[i]),
         .value         (cell_value[i]),
         .priority_out  (cell_prio[i])
      );
   end

   // response: cells only move on acceptance, so cell 0 holds the result
   assign count_ext         = {{bsmpq_pkg::COUNT_BITS{1'b0}}, count_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_value    = cell_valid[0] ? cell_value[0] : '0;
   assign rsp_head_priority = cell_valid[0] ? cell_prio[0] : '0;
   assign rsp_entry_count   = count_ext[bsmpq_pkg::COUNT_BITS-1:0];
   assign rsp_is_empty      = !cell_valid[0];
   assign rsp_status        = status_ff;

endmodule

// ===== hw/rtl/bsmpq_checker.sv =====
// ----------------------------------------------------------------------------
// bsmpq_checker
// Port-level checks of the priority queue core, bound to the core module.
// ----------------------------------------------------------------------------
module bsmpq_checker #(
   parameter int CAPACITY      = 16,
   parameter int VALUE_BITS    = 32,
   parameter int PRIORITY_BITS = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [bsmpq_pkg::OP_BITS-1:0]     req_op,
   input logic [VALUE_BITS-1:0]             req_item_value,
   input logic [PRIORITY_BITS-1:0]          req_item_priority,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [VALUE_BITS-1:0]             rsp_head_value,
   input logic [PRIORITY_BITS-1:0]          rsp_head_priority,
   input logic [bsmpq_pkg::COUNT_BITS-1:0]  rsp_entry_count,
   input logic                              rsp_is_empty,
   input logic [bsmpq_pkg::STATUS_BITS-1:0] rsp_status
);

   localparam logic [bsmpq_pkg::COUNT_BITS-1:0] CAP_COUNT =
      bsmpq_pkg::COUNT_BITS'(CAPACITY % (1 << bsmpq_pkg::COUNT_BITS));

   // stalled request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_op)
                                  && $stable(req_item_value) && $stable(req_item_priority))
      else $error("request changed while stalled");

   // stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // empty flag implies a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_entry_count == '0))
      else $error("empty flag and count disagree");

   // empty queue shows a zero head
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_head_value == '0) && (rsp_head_priority == '0))
      else $error("nonzero head on empty queue");

   // rejected enqueue only when full, rejected dequeue only when empty
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status != bsmpq_pkg::ST_FULL) || (rsp_entry_count == CAP_COUNT))
                 && ((rsp_status != bsmpq_pkg::ST_EMPTY) || rsp_is_empty))
      else $error("rejection status does not match fill level");

endmodule

bind bounded_stable_min_priority_queue_core bsmpq_checker #(
   .CAPACITY      (CAPACITY),
   .VALUE_BITS    (VALUE_BITS),
   .PRIORITY_BITS (PRIORITY_BITS)
) u_bsmpq_checker (.*);
